// File: rtl/vps_pkg.sv
// Shared types, constants and helpers of the vertex projection unit.
// No dependencies; every other file imports this package.
package vps_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = 48;
    localparam int H_W       = 50;
    localparam int MAG_W     = 49;
    localparam int Q_W       = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;

    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = Q_W / BITS_PER_STEP;
    // prep stage, quotient steps, saturation stage
    localparam int DIV_LAT       = DIV_STEPS + 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VPORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 3'd5;

    localparam logic [CFG_W-1:0] RST_ROW0  = 64'h0000_0000_0000_1000;
    localparam logic [CFG_W-1:0] RST_ROW1  = 64'h0000_0000_1000_0000;
    localparam logic [CFG_W-1:0] RST_ROW2  = 64'h0000_1000_0000_0000;
    localparam logic [CFG_W-1:0] RST_ROW3  = 64'h1000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_VPORT = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_DEPTH = 64'h03E8_0000_0000_199A;

    localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef logic signed [H_W-1:0]   t_h;
    typedef logic        [MAG_W-1:0] t_mag;
    typedef logic [CFG_W-1:0]        t_row [4];

    typedef struct packed {
        logic valid;
        logic wz;
    } t_ctl;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic signed [COORD_W-1:0] depth;
        logic                      w_zero;
    } t_res;

    // one restoring step: top bit is the quotient bit, the rest the new remainder
    function automatic logic [MAG_W:0] div_step(t_mag rem, logic b, t_mag ud);
        logic [MAG_W:0] t;
        logic [MAG_W:0] d;
        t = {rem, b};
        d = t - {1'b0, ud};
        if (t >= {1'b0, ud}) begin
            div_step = {1'b1, d[MAG_W-1:0]};
        end else begin
            div_step = {1'b0, t[MAG_W-1:0]};
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(logic signed [63:0] v);
        if (v > 64'(S32_MAX)) begin
            sat32 = S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            sat32 = S32_MIN;
        end else begin
            sat32 = v[COORD_W-1:0];
        end
    endfunction

endpackage

// File: rtl/vps_pt_if.sv
// Point channel: one object space position per beat.
// Depends on vps_pkg.
interface vps_pt_if import vps_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// File: rtl/vps_scr_if.sv
// Screen channel: one projected vertex per beat.
// Depends on vps_pkg.
interface vps_scr_if import vps_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic signed [COORD_W-1:0] depth;
    logic                      w_zero;

    modport source (output valid, screen_x, screen_y, depth, w_zero, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, w_zero, output ready);
endinterface

// File: rtl/vps_mat.sv
// Row vector times 4x4 Q3.12 matrix: products stage, then sum stage.
// Depends on vps_pkg.
module vps_mat import vps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_pos [3],
    input  t_row                      i_row,
    output logic                      o_valid,
    output t_h                        o_h [4]
);

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod [3][4];
    logic signed [31:0]       r_tr [4];
    logic                     r_v2;
    t_h                       r_h [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[i][j] <= i_pos[i] * $signed(i_row[i][16*j +: COEF_W]);
                end
                r_tr[j] <= $signed({i_row[3][16*j +: COEF_W], 16'h0000});
                r_h[j]  <= H_W'(r_prod[0][j]) + H_W'(r_prod[1][j])
                         + H_W'(r_prod[2][j]) + H_W'(r_tr[j]);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_h     = r_h;

endmodule

// File: rtl/vps_div.sv
// One lane of the pipelined Q16.16 divider, two quotient bits per stage,
// truncated toward zero and saturated. Depends on vps_pkg.
module vps_div import vps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_h                        i_num,
    input  t_h                        i_den,
    output logic signed [COORD_W-1:0] o_q
);

    t_mag             r_rem [DIV_STEPS+1];
    t_mag             r_ud  [DIV_STEPS+1];
    logic [Q_W-1:0]   r_low [DIV_STEPS+1];
    logic [Q_W-1:0]   r_q   [DIV_STEPS+1];
    logic             r_neg [DIV_STEPS+1];
    logic             r_ovf [DIV_STEPS+1];
    logic signed [COORD_W-1:0] r_out;

    t_h   n_un;
    t_h   n_ud;

    always_comb begin
        n_un = i_num[H_W-1] ? -i_num : i_num;
        n_ud = i_den[H_W-1] ? -i_den : i_den;
    end

    // prep: integer part overflows when |n| >= |d| * 2^16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_num[H_W-1] ^ i_den[H_W-1];
            r_ovf[0] <= {16'h0000, n_un[MAG_W-1:0]} >= {n_ud[MAG_W-1:0], 16'h0000};
            r_ud[0]  <= n_ud[MAG_W-1:0];
            r_rem[0] <= MAG_W'(n_un[MAG_W-1:16]);
            r_low[0] <= {n_un[15:0], 16'h0000};
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [MAG_W:0] n_a;
        logic [MAG_W:0] n_b;

        always_comb begin
            n_a = div_step(r_rem[s], r_low[s][Q_W-1], r_ud[s]);
            n_b = div_step(n_a[MAG_W-1:0], r_low[s][Q_W-2], r_ud[s]);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_b[MAG_W-1:0];
                r_ud[s+1]  <= r_ud[s];
                r_low[s+1] <= {r_low[s][Q_W-3:0], 2'b00};
                r_q[s+1]   <= {r_q[s][Q_W-3:0], n_a[MAG_W], n_b[MAG_W]};
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[DIV_STEPS]) begin
                if (r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > 32'h8000_0000)) begin
                    r_out <= S32_MIN;
                end else begin
                    r_out <= -$signed(r_q[DIV_STEPS]);
                end
            end else begin
                if (r_ovf[DIV_STEPS] || r_q[DIV_STEPS][Q_W-1]) begin
                    r_out <= S32_MAX;
                end else begin
                    r_out <= $signed(r_q[DIV_STEPS]);
                end
            end
        end
    end

    assign o_q = r_out;

endmodule

// File: rtl/vps_view.sv
// Viewport and depth range mapping: multiply stage, then offset and saturate.
// Depends on vps_pkg.
module vps_view import vps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_ctl                      i_ctl,
    input  logic signed [COORD_W-1:0] i_c [3],
    input  logic [CFG_W-1:0]          i_vport,
    input  logic [CFG_W-1:0]          i_range,
    output logic                      o_valid,
    output t_res                      o_res
);

    t_ctl                r_ctl1;
    logic signed [49:0]  r_px;
    logic signed [49:0]  r_py;
    logic signed [64:0]  r_pz;
    logic                r_v2;
    t_res                r_res;

    logic signed [32:0]  n_ax;
    logic signed [32:0]  n_ay;
    logic signed [32:0]  n_fn;
    logic signed [63:0]  n_sx;
    logic signed [63:0]  n_sy;
    logic signed [63:0]  n_dz;

    always_comb begin
        n_ax = 33'(i_c[0]) + 33'sd65536;
        n_ay = 33'sd65536 - 33'(i_c[1]);
        n_fn = 33'($signed(i_range[63:32])) - 33'($signed(i_range[31:0]));
        n_sx = $signed({32'h0, i_vport[15:0], 16'h0000}) + 64'(r_px >>> 1);
        n_sy = $signed({32'h0, i_vport[31:16], 16'h0000}) + 64'(r_py >>> 1);
        n_dz = 64'(r_pz >>> 16) + 64'($signed(i_range[31:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_v2   <= 1'b0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_v2   <= r_ctl1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_ax * $signed({1'b0, i_vport[47:32]});
            r_py <= n_ay * $signed({1'b0, i_vport[63:48]});
            r_pz <= i_c[2] * n_fn;
            if (r_ctl1.wz) begin
                r_res <= '{S32_MAX, S32_MAX, S32_MAX, 1'b1};
            end else begin
                r_res <= '{sat32(n_sx), sat32(n_sy), sat32(n_dz), 1'b0};
            end
        end
    end

    assign o_valid = r_v2;
    assign o_res   = r_res;

endmodule

// File: rtl/vertex_project_to_screen_unit.sv
// Top level of the vertex projection unit: config registers, matrix stages,
// three divider lanes, viewport stages and the output skid stage.
// Depends on vps_pkg, vps_pt_if, vps_scr_if, vps_mat, vps_div, vps_view.
//
//  port    dir  beat contents
//  i_pt    in   pos_x, pos_y, pos_z (signed Q16.16)
//  o_scr   out  screen_x, screen_y, depth (signed Q16.16), w_zero
//  i_cfg_* in   register write: enable, index 0..5, 64-bit data
//
// One vertex per cycle sustained while o_scr is not stalled; the path from
// accept to output register is set mostly by the 16 two-bit divider stages.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall on o_scr fills the skid stage; the whole pipeline then holds and
// i_pt.ready drops until the skid stage drains.
module vertex_project_to_screen_unit import vps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vps_pt_if.sink               i_pt,
    vps_scr_if.source            o_scr,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    t_ctl             r_dctl [DIV_LAT];
    logic             r_o_v;
    t_res             r_o;
    logic             r_sk_v;
    t_res             r_sk;

    logic                      en;
    logic signed [COORD_W-1:0] pos [3];
    t_row                      rows;
    logic                      mat_v;
    t_h                        h [4];
    logic signed [COORD_W-1:0] c [3];
    logic                      view_v;
    t_res                      view_res;

    assign en = !r_sk_v;
    assign i_pt.ready = en;
    assign pos = '{i_pt.pos_x, i_pt.pos_y, i_pt.pos_z};
    assign rows = '{r_cfg[REG_ROW0], r_cfg[REG_ROW1], r_cfg[REG_ROW2], r_cfg[REG_ROW3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROW0]  <= RST_ROW0;
            r_cfg[REG_ROW1]  <= RST_ROW1;
            r_cfg[REG_ROW2]  <= RST_ROW2;
            r_cfg[REG_ROW3]  <= RST_ROW3;
            r_cfg[REG_VPORT] <= RST_VPORT;
            r_cfg[REG_DEPTH] <= RST_DEPTH;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    vps_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pt.valid),
        .i_pos   (pos),
        .i_row   (rows),
        .o_valid (mat_v),
        .o_h     (h)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        vps_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (h[k]),
            .i_den (h[3]),
            .o_q   (c[k])
        );
    end

    // control rides alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_dctl[s] <= '0;
            end
        end else if (en) begin
            r_dctl[0] <= '{mat_v, (h[3] == '0)};
            for (int s = 1; s < DIV_LAT; s++) begin
                r_dctl[s] <= r_dctl[s-1];
            end
        end
    end

    vps_view u_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_dctl[DIV_LAT-1]),
        .i_c     (c),
        .i_vport (r_cfg[REG_VPORT]),
        .i_range (r_cfg[REG_DEPTH]),
        .o_valid (view_v),
        .o_res   (view_res)
    );

    // output register with skid: drain skid first, else take the new beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (o_scr.ready || !r_o_v) begin
            if (r_sk_v) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_o_v <= view_v;
            end
        end else if (view_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_scr.ready || !r_o_v) begin
            r_o <= r_sk_v ? r_sk : view_res;
        end else if (en) begin
            r_sk <= view_res;
        end
    end

    assign o_scr.valid    = r_o_v;
    assign o_scr.screen_x = r_o.screen_x;
    assign o_scr.screen_y = r_o.screen_y;
    assign o_scr.depth    = r_o.depth;
    assign o_scr.w_zero   = r_o.w_zero;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v) else $error("skid holds a beat while output is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && !o_scr.ready) |=> (r_sk_v && $stable(r_sk)))
        else $error("skid beat lost during stall");

    a_wz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_scr.valid && o_scr.w_zero) |->
        (o_scr.screen_x == S32_MAX && o_scr.screen_y == S32_MAX && o_scr.depth == S32_MAX))
        else $error("w zero beat not saturated");

    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !o_scr.ready && !r_sk_v && view_v) |=> r_sk_v)
        else $error("beat dropped at stalled output");
`endif

endmodule
